@@ rtl/kclc_pkg.sv @@
// Shared types and constants for the keystore container length check.
// Used by kclc_front, kclc_parse and the top level; no dependencies.
`timescale 1ns / 1ps

package kclc_pkg;

	localparam int DATA_W        = 8;
	localparam int LEN_W         = 25;
	localparam int FIELD_W       = 32;
	localparam int CNT_W         = 3;
	localparam int QUEUE_DEPTH   = 2;
	localparam int MAX_ENTRIES_D = 1024;
	localparam int MAX_CHAIN_D   = 1024;

	localparam logic [LEN_W-1:0] MAX_LEN_RESET = 25'h100_0000;

	// one byte request as it sits in the queue
	typedef struct packed {
		logic              start_req;
		logic [DATA_W-1:0] data_byte;
	} qent_t;

	// queue head as seen by the parser
	typedef struct packed {
		logic  valid;
		qent_t ent;
	} qhead_t;

endpackage

@@ rtl/kclc_front.sv @@
// Front end: accepts byte requests and holds them in a short queue.
// Depends on kclc_pkg.
`timescale 1ns / 1ps

module kclc_front #(
	parameter int DEPTH = kclc_pkg::QUEUE_DEPTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [kclc_pkg::DATA_W-1:0]  data_byte,
	input  logic                         start_req,
	input  logic                         pop,
	output kclc_pkg::qhead_t             head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	kclc_pkg::qent_t  mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    cnt_q;
	logic             push;
	logic             pull;

	assign in_ready = (cnt_q != CW'(DEPTH));
	assign push     = in_valid && in_ready;
	assign pull     = pop && (cnt_q != '0);

	assign head.valid = (cnt_q != '0);
	assign head.ent   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= '{start_req: start_req, data_byte: data_byte};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pull) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pull})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

@@ rtl/kclc_parse.sv @@
// Back end: walks the keystore structure one byte per cycle unless a new result
// meets one still waiting; registers at most one result per candidate. Depends on kclc_pkg.
`timescale 1ns / 1ps

module kclc_parse #(
	parameter int MAX_ENTRIES = kclc_pkg::MAX_ENTRIES_D,
	parameter int MAX_CHAIN   = kclc_pkg::MAX_CHAIN_D
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [kclc_pkg::LEN_W-1:0]   cfg_data,
	input  kclc_pkg::qhead_t             head,
	output logic                         pop,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         valid_res,
	output logic [kclc_pkg::LEN_W-1:0]   length
);

	localparam int LW  = kclc_pkg::LEN_W;
	localparam int FW  = kclc_pkg::FIELD_W;
	localparam int DW  = kclc_pkg::DATA_W;
	localparam int CNW = kclc_pkg::CNT_W;
	localparam int ENT_W = $clog2(MAX_ENTRIES + 1);
	localparam int CRT_W = $clog2(MAX_CHAIN + 1);
	// header 12, alias length 2, timestamp 8, key length 4, chain count 4
	localparam logic [LW-1:0] MIN_VALID_LEN = LW'(30);

	typedef enum logic [10:0] {
		PH_IDLE       = 11'b000_0000_0001,
		PH_MAGIC      = 11'b000_0000_0010,
		PH_VER        = 11'b000_0000_0100,
		PH_COUNT      = 11'b000_0000_1000,
		PH_ALIAS_LEN  = 11'b000_0001_0000,
		PH_ALIAS_SKIP = 11'b000_0010_0000,
		PH_KEY_LEN    = 11'b000_0100_0000,
		PH_KEY_SKIP   = 11'b000_1000_0000,
		PH_CHAIN      = 11'b001_0000_0000,
		PH_CERT_LEN   = 11'b010_0000_0000,
		PH_CERT_SKIP  = 11'b100_0000_0000
	} phase_t;

	phase_t             phase_q;
	logic [CNW-1:0]     cnt_q;
	logic [FW-1:0]      fld_q;
	logic [LW-1:0]      pos_q;
	logic [ENT_W-1:0]   ent_q;
	logic [CRT_W-1:0]   crt_q;
	logic [LW-1:0]      skp_q;
	logic [LW-1:0]      max_len_q;
	logic               out_valid_q;
	logic               valid_res_q;
	logic [LW-1:0]      length_q;

	phase_t             ph_b, ph_d, enter_ph;
	logic [CNW-1:0]     cnt_b, cnt_d, cnt_inc;
	logic [FW-1:0]      fld_b, fld_d, sh, addend;
	logic [LW-1:0]      pos_b, pos_d, pos_n;
	logic [ENT_W-1:0]   ent_b, ent_d, ent_dec;
	logic [CRT_W-1:0]   crt_b, crt_d, crt_src;
	logic [LW-1:0]      skp_b, skp_d, skp_dec;
	logic               start;
	logic               done2, done4;
	logic               big_fail, fail2, fail4;
	logic               go_cert, go_entry, enter, enter_fail;
	logic               fin, fin_ok;
	logic               res, res_ok;

	assign start = head.ent.start_req;

	always_comb begin
		ph_b  = start ? PH_MAGIC : phase_q;
		pos_b = start ? '0 : pos_q;
		cnt_b = start ? '0 : cnt_q;
		fld_b = start ? '0 : fld_q;
		ent_b = start ? '0 : ent_q;
		crt_b = start ? '0 : crt_q;
		skp_b = start ? '0 : skp_q;

		pos_n   = pos_b + 1'b1;
		sh      = {fld_b[FW-DW-1:0], head.ent.data_byte};
		cnt_inc = cnt_b + 1'b1;
		done2   = (cnt_inc >= CNW'(2));
		done4   = (cnt_inc >= CNW'(4));
		addend  = (ph_b == PH_ALIAS_LEN) ? ({16'b0, sh[15:0]} + 32'd8) : sh;
		// one wide limit compare, shared by the alias, key and certificate length checks
		big_fail = ({8'b0, pos_n} + {1'b0, addend}) > {8'b0, max_len_q};
		fail2    = ({1'b0, pos_n} + (LW+1)'(2)) > {1'b0, max_len_q};
		fail4    = ({1'b0, pos_n} + (LW+1)'(4)) > {1'b0, max_len_q};
		ent_dec  = (ent_b != '0) ? ent_b - 1'b1 : '0;
		skp_dec  = (skp_b != '0) ? skp_b - 1'b1 : '0;

		ph_d  = ph_b;
		pos_d = pos_b;
		cnt_d = cnt_b;
		fld_d = fld_b;
		ent_d = ent_b;
		crt_d = crt_b;
		skp_d = skp_b;

		go_cert    = 1'b0;
		go_entry   = 1'b0;
		enter      = 1'b0;
		enter_fail = 1'b0;
		enter_ph   = PH_IDLE;
		crt_src    = crt_b;
		fin        = 1'b0;
		fin_ok     = 1'b0;

		if (ph_b != PH_IDLE) begin
			pos_d = pos_n;
			case (ph_b)
				PH_MAGIC: begin
					if (pos_n >= LW'(4)) begin
						ph_d  = PH_VER;
						cnt_d = '0;
						fld_d = '0;
					end
				end
				PH_VER: begin
					cnt_d = cnt_inc;
					fld_d = sh;
					if (done4) begin
						if (sh != 32'd1 && sh != 32'd2) begin
							fin = 1'b1;
						end else begin
							ph_d  = PH_COUNT;
							cnt_d = '0;
							fld_d = '0;
						end
					end
				end
				PH_COUNT: begin
					cnt_d = cnt_inc;
					fld_d = sh;
					if (done4) begin
						if (sh == '0 || sh > 32'(MAX_ENTRIES)) begin
							fin = 1'b1;
						end else begin
							ent_d      = sh[ENT_W-1:0];
							enter      = 1'b1;
							enter_ph   = PH_ALIAS_LEN;
							enter_fail = fail2;
						end
					end
				end
				PH_ALIAS_LEN: begin
					cnt_d = cnt_inc;
					fld_d = sh;
					if (done2) begin
						if (big_fail) begin
							fin = 1'b1;
						end else begin
							skp_d = addend[LW-1:0];
							ph_d  = PH_ALIAS_SKIP;
						end
					end
				end
				PH_ALIAS_SKIP: begin
					skp_d = skp_dec;
					if (skp_dec == '0) begin
						enter      = 1'b1;
						enter_ph   = PH_KEY_LEN;
						enter_fail = fail4;
					end
				end
				PH_KEY_LEN: begin
					cnt_d = cnt_inc;
					fld_d = sh;
					if (done4) begin
						if (big_fail) begin
							fin = 1'b1;
						end else if (sh == '0) begin
							enter      = 1'b1;
							enter_ph   = PH_CHAIN;
							enter_fail = fail4;
						end else begin
							skp_d = sh[LW-1:0];
							ph_d  = PH_KEY_SKIP;
						end
					end
				end
				PH_KEY_SKIP: begin
					skp_d = skp_dec;
					if (skp_dec == '0) begin
						enter      = 1'b1;
						enter_ph   = PH_CHAIN;
						enter_fail = fail4;
					end
				end
				PH_CHAIN: begin
					cnt_d = cnt_inc;
					fld_d = sh;
					if (done4) begin
						if (sh > 32'(MAX_CHAIN)) begin
							fin = 1'b1;
						end else begin
							crt_src = sh[CRT_W-1:0];
							go_cert = 1'b1;
						end
					end
				end
				PH_CERT_LEN: begin
					cnt_d = cnt_inc;
					fld_d = sh;
					if (done4) begin
						if (big_fail) begin
							fin = 1'b1;
						end else if (sh == '0) begin
							go_cert = 1'b1;
						end else begin
							skp_d = sh[LW-1:0];
							ph_d  = PH_CERT_SKIP;
						end
					end
				end
				PH_CERT_SKIP: begin
					skp_d = skp_dec;
					if (skp_dec == '0) begin
						go_cert = 1'b1;
					end
				end
				default: begin
					ph_d = PH_IDLE;
				end
			endcase
		end

		// next certificate, or close the entry when the chain is done
		if (go_cert) begin
			if (crt_src == '0) begin
				go_entry = 1'b1;
			end else begin
				crt_d      = crt_src - 1'b1;
				enter      = 1'b1;
				enter_ph   = PH_CERT_LEN;
				enter_fail = fail4;
			end
		end
		if (go_entry) begin
			ent_d = ent_dec;
			if (ent_dec == '0) begin
				fin    = 1'b1;
				fin_ok = 1'b1;
			end else begin
				enter      = 1'b1;
				enter_ph   = PH_ALIAS_LEN;
				enter_fail = fail2;
			end
		end
		if (enter) begin
			if (enter_fail) begin
				fin = 1'b1;
			end else begin
				ph_d  = enter_ph;
				cnt_d = '0;
				fld_d = '0;
			end
		end
		if (fin) begin
			ph_d = PH_IDLE;
		end
		res    = fin;
		res_ok = fin_ok;
	end

	// a byte that gives no result never waits on the output side
	assign pop = head.valid && (!out_valid_q || out_ready || !res);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			cnt_q       <= '0;
			fld_q       <= '0;
			pos_q       <= '0;
			ent_q       <= '0;
			crt_q       <= '0;
			skp_q       <= '0;
			max_len_q   <= kclc_pkg::MAX_LEN_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				max_len_q <= cfg_data;
			end
			if (pop) begin
				phase_q <= ph_d;
				cnt_q   <= cnt_d;
				fld_q   <= fld_d;
				pos_q   <= pos_d;
				ent_q   <= ent_d;
				crt_q   <= crt_d;
				skp_q   <= skp_d;
			end
			if (pop && res) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && res) begin
			valid_res_q <= res_ok;
			length_q    <= res_ok ? pos_n : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign valid_res = valid_res_q;
	assign length    = length_q;

`ifndef SYNTHESIS
	a_valid_min_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && valid_res_q |-> length_q >= MIN_VALID_LEN)
		else $error("valid result shorter than smallest structure");

	a_reject_zero_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !valid_res_q |-> length_q == '0)
		else $error("rejected result carries a length");

	a_skip_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_ALIAS_SKIP || phase_q == PH_KEY_SKIP ||
		 phase_q == PH_CERT_SKIP) |-> skp_q != '0)
		else $error("skip phase with empty skip counter");
`endif

endmodule

@@ rtl/keystore_container_length_check_unit.sv @@
// Keystore container length check, top level.
// Depends on kclc_pkg, kclc_front and kclc_parse.
//
// Usage:
//   Input channel (in_valid/in_ready, data_byte, start_req) carries one byte
//   request per cycle while in_ready holds. start_req marks the first magic
//   byte of a candidate and restarts the parse. Bytes outside a candidate are consumed silently.
//   Output channel (out_valid/out_ready, valid_res, length) carries at most
//   one result per candidate: valid_res=1 with the structure length, or
//   valid_res=0 with length 0. Later bytes are dropped until the next start.
//   cfg_we/cfg_data write max_len (reset 16777216); write only while idle.
// Timing:
//   One byte per cycle, set by the single-byte parse step in the back end,
//   while no result is held up by out_ready. A result shows once the byte that
//   ends the candidate has passed the queue and the parse step has loaded the
//   output register.
//   While a result waits for out_ready, bytes that give no result still flow
//   through the two-entry queue; it fills only when a second result is due.
// Reset (arst_n low) empties the queue, drops any pending result and idles
// the parser.
`timescale 1ns / 1ps

module keystore_container_length_check_unit #(
	parameter int MAX_ENTRIES = kclc_pkg::MAX_ENTRIES_D,
	parameter int MAX_CHAIN   = kclc_pkg::MAX_CHAIN_D
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [kclc_pkg::DATA_W-1:0]  data_byte,
	input  logic                         start_req,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         valid_res,
	output logic [kclc_pkg::LEN_W-1:0]   length,
	input  logic                         cfg_we,
	input  logic [kclc_pkg::LEN_W-1:0]   cfg_data
);

	kclc_pkg::qhead_t head;
	logic             pop;

	kclc_front #(
		.DEPTH (kclc_pkg::QUEUE_DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.data_byte (data_byte),
		.start_req (start_req),
		.pop       (pop),
		.head      (head)
	);

	kclc_parse #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.MAX_CHAIN   (MAX_CHAIN)
	) u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.valid_res (valid_res),
		.length    (length)
	);

endmodule

@@ tb/sv/keystore_container_length_check_unit_tb.sv @@
// Self-checking testbench for keystore_container_length_check_unit.
// Depends on kclc_pkg and the unit; a directed table of candidates, then random
// candidates, checked against an in-bench byte-walk predictor or, for typed rows, the table's verdict.
`timescale 1ns / 1ps

module keystore_container_length_check_unit_tb;

	localparam int          DATA_W        = kclc_pkg::DATA_W;
	localparam int          LEN_W         = kclc_pkg::LEN_W;
	localparam int          MAX_ENTRIES_D = kclc_pkg::MAX_ENTRIES_D;
	localparam int          MAX_CHAIN_D   = kclc_pkg::MAX_CHAIN_D;
	localparam logic [LEN_W-1:0] MAX_LEN_RESET = kclc_pkg::MAX_LEN_RESET;

	localparam int          STALL_LIMIT   = 4000;  // cycles with no request moving
	localparam int          SETTLE_CYCLES = 12;    // queue + parse step, with margin
	localparam int          RANDOM_BYTES  = 1350;
	localparam int          RANDOM_PHASES = 5;
	localparam int          NOISE_PCT     = 8;
	localparam int          IDLE_PCT      = 7;
	localparam int          BUILD_CAP     = 1030;  // enough entries/certs to trip the caps
	localparam bit [31:0]   BIG_FLAG      = 32'h8000_0000;
	localparam [LEN_W-1:0]  LIM_TOP       = 25'h100_0000;
	localparam [LEN_W-1:0]  LIM_FLOOR     = 25'd16;

	// parse position inside one candidate
	typedef enum logic [3:0] {
		ST_IDLE, ST_MAGIC, ST_VER, ST_COUNT, ST_ALIAS_LEN, ST_ALIAS_SKIP,
		ST_KEY_LEN, ST_KEY_SKIP, ST_CHAIN, ST_CERT_LEN, ST_CERT_SKIP
	} walk_t;

	typedef struct packed {
		bit             ok;
		bit [LEN_W-1:0] len;
	} verdict_t;

	// one candidate; every entry repeats the same sizes
	typedef struct {
		bit [LEN_W-1:0] new_lim;   // 0 keeps the current limit
		bit             loose;     // sent with no start flag at all
		bit [31:0]      ver, cnt;
		bit [15:0]      name_len;
		bit [31:0]      key_len, chain, cert_len;
		int             cut;       // restart point, -1 for the whole candidate
		int             trail;     // junk bytes after the verdict
		bit             typed;
		bit             want_ok;
		bit [LEN_W-1:0] want_len;
	} recipe_t;

	logic              clk;
	logic              arst_n    = 1'b0;
	logic              in_valid  = 1'b0;
	logic              in_ready;
	logic [DATA_W-1:0] data_byte = '0;
	logic              start_req = 1'b0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic              valid_res;
	logic [LEN_W-1:0]  length;
	logic              cfg_we    = 1'b0;
	logic [LEN_W-1:0]  cfg_data  = '0;

	keystore_container_length_check_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.data_byte (data_byte),
		.start_req (start_req),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.valid_res (valid_res),
		.length    (length),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------------
	// Predictor state: a private copy of the parser and its limit register
	// ---------------------------------------------------------------------
	walk_t          walk       = ST_IDLE;
	bit [2:0]       fld_cnt    = '0;
	bit [31:0]      fld_acc    = '0;
	bit [LEN_W-1:0] pos        = '0;
	bit [10:0]      ents_left  = '0;
	bit [10:0]      certs_left = '0;
	bit [LEN_W-1:0] skip       = '0;
	bit [LEN_W-1:0] lim        = MAX_LEN_RESET;

	// verdict produced by the byte just walked
	bit             res_hit;
	verdict_t       res_got;

	verdict_t       pending_verdicts[$];
	bit [7:0]       stream[$];
	bit             use_typed     = 1'b0;
	verdict_t       typed_verdict = '0;
	bit             steady        = 1'b0;   // no idling on either side while set

	int fail_count   = 0;
	int n_bytes      = 0;
	int n_results    = 0;
	int n_ok         = 0;
	int n_bad        = 0;
	int n_limits     = 0;
	int quiet_cycles = 0;

	// does a field or body of 'extra' bytes still end inside the limit
	function automatic bit fits(bit [31:0] extra);
		bit [33:0] sum;
		sum = {9'd0, pos} + {2'd0, extra};
		return sum <= {9'd0, lim};
	endfunction

	function automatic void close_candidate(bit ok);
		res_hit     = 1'b1;
		res_got.ok  = ok;
		res_got.len = ok ? pos : '0;
		walk        = ST_IDLE;
	endfunction

	function automatic void open_field(walk_t nxt, bit [31:0] size);
		if (!fits(size)) begin
			close_candidate(1'b0);
		end else begin
			walk    = nxt;
			fld_cnt = '0;
			fld_acc = '0;
		end
	endfunction

	function automatic void entry_done();
		if (ents_left != 0)
			ents_left--;
		if (ents_left == 0)
			close_candidate(1'b1);
		else
			open_field(ST_ALIAS_LEN, 2);
	endfunction

	function automatic void cert_next();
		if (certs_left == 0) begin
			entry_done();
		end else begin
			certs_left--;
			open_field(ST_CERT_LEN, 4);
		end
	endfunction

	function automatic bit shift_in(bit [7:0] b, int size);
		fld_acc = {fld_acc[23:0], b};
		fld_cnt++;
		return fld_cnt >= size;
	endfunction

	// advance the predictor by one accepted byte request
	function automatic void walk_keystore_byte(bit [7:0] b, bit st);
		bit [31:0] v;
		res_hit = 1'b0;
		if (st) begin
			walk       = ST_MAGIC;
			pos        = '0;
			fld_cnt    = '0;
			fld_acc    = '0;
			ents_left  = '0;
			certs_left = '0;
			skip       = '0;
		end
		if (walk == ST_IDLE)
			return;
		pos = pos + 1'b1;
		case (walk)
			ST_MAGIC: begin
				if (pos >= 4) begin
					walk    = ST_VER;
					fld_cnt = '0;
					fld_acc = '0;
				end
			end
			ST_VER: begin
				if (shift_in(b, 4)) begin
					if (fld_acc != 1 && fld_acc != 2) begin
						close_candidate(1'b0);
					end else begin
						walk    = ST_COUNT;
						fld_cnt = '0;
						fld_acc = '0;
					end
				end
			end
			ST_COUNT: begin
				if (shift_in(b, 4)) begin
					if (fld_acc < 1 || fld_acc > MAX_ENTRIES_D) begin
						close_candidate(1'b0);
					end else begin
						ents_left = fld_acc[10:0];
						open_field(ST_ALIAS_LEN, 2);
					end
				end
			end
			ST_ALIAS_LEN: begin
				if (shift_in(b, 2)) begin
					// alias body plus the 8 timestamp bytes
					v = {16'd0, fld_acc[15:0]} + 32'd8;
					if (!fits(v)) begin
						close_candidate(1'b0);
					end else begin
						skip = v[LEN_W-1:0];
						walk = ST_ALIAS_SKIP;
					end
				end
			end
			ST_ALIAS_SKIP: begin
				if (skip != 0)
					skip--;
				if (skip == 0)
					open_field(ST_KEY_LEN, 4);
			end
			ST_KEY_LEN: begin
				if (shift_in(b, 4)) begin
					v = fld_acc;
					if (!fits(v)) begin
						close_candidate(1'b0);
					end else if (v == 0) begin
						open_field(ST_CHAIN, 4);
					end else begin
						skip = v[LEN_W-1:0];
						walk = ST_KEY_SKIP;
					end
				end
			end
			ST_KEY_SKIP: begin
				if (skip != 0)
					skip--;
				if (skip == 0)
					open_field(ST_CHAIN, 4);
			end
			ST_CHAIN: begin
				if (shift_in(b, 4)) begin
					if (fld_acc > MAX_CHAIN_D) begin
						close_candidate(1'b0);
					end else begin
						certs_left = fld_acc[10:0];
						cert_next();
					end
				end
			end
			ST_CERT_LEN: begin
				if (shift_in(b, 4)) begin
					v = fld_acc;
					if (!fits(v)) begin
						close_candidate(1'b0);
					end else if (v == 0) begin
						cert_next();
					end else begin
						skip = v[LEN_W-1:0];
						walk = ST_CERT_SKIP;
					end
				end
			end
			ST_CERT_SKIP: begin
				if (skip != 0)
					skip--;
				if (skip == 0)
					cert_next();
			end
			default: walk = ST_IDLE;
		endcase
	endfunction

	// ---------------------------------------------------------------------
	// Candidate byte builder
	// ---------------------------------------------------------------------
	function automatic void put8(bit [7:0] b);
		stream.insert(stream.size(), b);
	endfunction

	function automatic void put32(bit [31:0] w);
		put8(w[31:24]);
		put8(w[23:16]);
		put8(w[15:8]);
		put8(w[7:0]);
	endfunction

	function automatic void put_filler(longint n);
		for (longint i = 0; i < n; i++)
			put8(8'($urandom));
	endfunction

	// a body that would overrun the limit is never needed: the parser rejects
	// the candidate at its length field, so building stops there
	function automatic bit overruns(bit [31:0] n);
		return longint'(stream.size()) + longint'(n) > longint'(lim);
	endfunction

	function automatic void build_stream(recipe_t r);
		stream.delete();
		put_filler(4);                       // magic, never checked
		put32(r.ver);
		put32(r.cnt);
		for (int e = 0; e < r.cnt && e < BUILD_CAP; e++) begin
			put8(r.name_len[15:8]);
			put8(r.name_len[7:0]);
			if (overruns({16'd0, r.name_len} + 32'd8))
				return;
			put_filler(longint'(r.name_len) + 8);
			put32(r.key_len);
			if (overruns(r.key_len))
				return;
			put_filler(longint'(r.key_len));
			put32(r.chain);
			for (int c = 0; c < r.chain && c < BUILD_CAP; c++) begin
				put32(r.cert_len);
				if (overruns(r.cert_len))
					return;
				put_filler(longint'(r.cert_len));
			end
		end
	endfunction

	function automatic recipe_t roll_recipe();
		recipe_t r;
		int      pick;
		r = '{default: '0};
		r.ver = ($urandom_range(0, 9) != 0) ? 32'($urandom_range(1, 2)) : 32'($urandom);
		pick = $urandom_range(0, 99);
		r.cnt = (pick < 88) ? 32'($urandom_range(1, 3)) :
			(pick < 92) ? 32'd0 :
			(pick < 96) ? 32'($urandom_range(MAX_ENTRIES_D + 1, 2047)) : 32'($urandom);
		pick = $urandom_range(0, 99);
		// a full 64 KiB alias only where the limit cuts it short
		r.name_len = (pick < 95) ? 16'($urandom_range(0, 6)) :
			(lim < 5000) ? 16'($urandom) : 16'($urandom_range(7, 40));
		pick = $urandom_range(0, 99);
		r.key_len = (pick < 85) ? 32'($urandom_range(0, 10)) :
			(pick < 95) ? 32'($urandom_range(0, 60)) : (32'($urandom) | BIG_FLAG);
		pick = $urandom_range(0, 99);
		r.chain = (pick < 85) ? 32'($urandom_range(0, 2)) :
			(pick < 93) ? 32'($urandom_range(MAX_CHAIN_D + 1, 4096)) : 32'($urandom);
		pick = $urandom_range(0, 99);
		r.cert_len = (pick < 90) ? 32'($urandom_range(0, 8)) :
			(pick < 96) ? 32'($urandom_range(0, 60)) : (32'($urandom) | BIG_FLAG);
		r.cut   = ($urandom_range(0, 99) < 6) ? int'($urandom_range(1, 24)) : -1;
		r.trail = $urandom_range(0, 3);
		return r;
	endfunction

	// ---------------------------------------------------------------------
	// Request driver: random gaps before valid rises, never while it is high
	// ---------------------------------------------------------------------
	task automatic push_byte(bit [7:0] b, bit st);
		while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		data_byte <= b;
		start_req <= st;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		n_bytes++;
		walk_keystore_byte(b, st);
		if (res_hit)
			pending_verdicts.insert(pending_verdicts.size(),
				use_typed ? typed_verdict : res_got);
	endtask

	// hold off new requests until every verdict is back and the queue is empty
	task automatic settle_idle();
		in_valid <= 1'b0;
		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	// a zero version ends any open candidate with a reject
	task automatic close_open_candidate();
		if (walk != ST_IDLE) begin
			push_byte(8'($urandom), 1'b1);
			repeat (3) push_byte(8'($urandom), 1'b0);
			repeat (4) push_byte(8'h00, 1'b0);
		end
	endtask

	task automatic set_limit(bit [LEN_W-1:0] v);
		close_open_candidate();
		settle_idle();
		cfg_we   <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we   <= 1'b0;
		lim = v;
		n_limits++;
	endtask

	task automatic run_recipe(recipe_t r);
		if (r.new_lim != 0)
			set_limit(r.new_lim);
		build_stream(r);
		use_typed     = r.typed;
		typed_verdict = '{ok: r.want_ok, len: r.want_len};
		for (int i = 0; i < stream.size(); i++) begin
			if (i == r.cut)
				break;
			push_byte(stream[i], !r.loose && i == 0);
			if (!r.loose && walk == ST_IDLE)
				break;
		end
		use_typed = 1'b0;
		repeat (r.trail)
			push_byte(8'($urandom), 1'b0);
	endtask

	// ---------------------------------------------------------------------
	// Directed candidates. Columns: new limit, loose, version, count,
	// alias len, key len, chain, cert len, cut, trail, typed, ok, length.
	// ---------------------------------------------------------------------
	recipe_t plan [19] = '{
		// minimal entry at the reset limit, junk after the verdict ignored
		'{0, 0, 1, 1, 0, 0, 0, 0, -1, 5, 1, 1, 30},
		'{0, 0, 2, 1, 3, 5, 2, 4, -1, 0, 0, 0, 0},
		// whole structure without a start flag: nothing comes back
		'{0, 1, 1, 1, 0, 0, 0, 0, -1, 0, 0, 0, 0},
		// bad versions
		'{0, 0, 0, 1, 0, 0, 0, 0, -1, 2, 1, 0, 0},
		'{0, 0, 3, 1, 0, 0, 0, 0, -1, 0, 1, 0, 0},
		'{0, 0, 32'hFFFF_FFFF, 1, 0, 0, 0, 0, -1, 0, 1, 0, 0},
		// entry count out of range; the largest legal count is taken, so
		// restarting after the first alias length field leaves no result
		'{0, 0, 1, 0, 0, 0, 0, 0, -1, 0, 1, 0, 0},
		'{0, 0, 1, 1025, 0, 0, 0, 0, -1, 0, 1, 0, 0},
		'{0, 0, 2, 1024, 0, 0, 0, 0, 14, 0, 0, 0, 0},
		// longest legal chain is taken (no result before the restart),
		// one more is rejected
		'{0, 0, 1, 1, 0, 0, 1024, 0, 30, 0, 0, 0, 0},
		'{0, 0, 1, 1, 0, 0, 1025, 0, -1, 0, 1, 0, 0},
		// largest alias passes its check, oversized key and certificate fail
		'{0, 0, 1, 1, 16'hFFFF, 0, 0, 0, 14, 0, 0, 0, 0},
		'{0, 0, 1, 1, 0, 32'hFFFF_FFFF, 0, 0, -1, 0, 1, 0, 0},
		'{0, 0, 2, 1, 0, 0, 1, 32'hFFFF_FFFF, -1, 0, 1, 0, 0},
		// restart in the middle of a candidate
		'{0, 0, 2, 2, 2, 3, 1, 2, 20, 0, 0, 0, 0},
		'{0, 0, 2, 3, 1, 1, 1, 1, -1, 0, 0, 0, 0},
		// limit exactly at the minimal structure, one below, and the floor
		'{25'd30, 0, 1, 1, 0, 0, 0, 0, -1, 0, 1, 1, 30},
		'{25'd29, 0, 1, 1, 0, 0, 0, 0, -1, 0, 1, 0, 0},
		'{LIM_FLOOR, 0, 1, 1, 0, 0, 0, 0, -1, 0, 1, 0, 0}
	};

	// ---------------------------------------------------------------------
	// Result side: random back-pressure and the scoreboard
	// ---------------------------------------------------------------------
	always @(posedge clk)
		out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);

	always @(posedge clk) begin
		verdict_t want;
		if (arst_n && out_valid && out_ready) begin
			n_results++;
			if (valid_res)
				n_ok++;
			else
				n_bad++;
			if (pending_verdicts.size() == 0) begin
				$display("%0t: result with none expected: valid_res %0d length %0d",
					$time, valid_res, length);
				fail_count++;
			end else begin
				want = pending_verdicts.pop_front();
				if (valid_res !== want.ok) begin
					$display("%0t: valid_res expected %0d actual %0d",
						$time, want.ok, valid_res);
					fail_count++;
				end
				if (length !== want.len) begin
					$display("%0t: length expected %0d actual %0d",
						$time, want.len, length);
					fail_count++;
				end
			end
		end
	end

	// watchdog: a hang shows up as a long run with no request moving
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles == STALL_LIMIT) begin
				$display("%0t: stalled, %0d verdicts outstanding",
					$time, pending_verdicts.size());
				$display("FAIL");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------------
	initial begin
		bit [LEN_W-1:0] phase_lim [RANDOM_PHASES];
		recipe_t        r;
		int             phase_start;

		repeat (12)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i])
			run_recipe(plan[i]);

		// random part: limits at both extremes and in between
		phase_lim[0] = LIM_TOP;
		phase_lim[1] = 25'($urandom_range(24, 120));
		phase_lim[2] = LIM_FLOOR;
		phase_lim[3] = 25'($urandom_range(300, 3000));
		phase_lim[4] = LIM_TOP;
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			set_limit(phase_lim[p]);
			steady      = (p == 1);   // one phase runs with no idling at all
			phase_start = n_bytes;
			while (n_bytes - phase_start < RANDOM_BYTES / RANDOM_PHASES) begin
				if ($urandom_range(0, 99) < NOISE_PCT) begin
					// junk, now and then with a stray start flag
					repeat ($urandom_range(1, 12))
						push_byte(8'($urandom), $urandom_range(0, 9) == 0);
				end else begin
					r = roll_recipe();
					run_recipe(r);
				end
				if ($urandom_range(0, 39) == 0)
					settle_idle();
			end
		end
		steady = 1'b0;

		in_valid <= 1'b0;
		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES * 2)
			@(posedge clk);

		$display("Run covered %0d byte requests under %0d limit settings.", n_bytes, n_limits);
		$display("Checked %0d verdicts: %0d complete structures, %0d rejected.",
			n_results, n_ok, n_bad);
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

@@ keystore_container_length_check_unit.f @@
rtl/kclc_pkg.sv
rtl/kclc_front.sv
rtl/kclc_parse.sv
rtl/keystore_container_length_check_unit.sv
tb/sv/keystore_container_length_check_unit_tb.sv
